// ===== hdl/orl_pkg.sv =====
package orl_pkg;

  // Ring geometry and record width.
  localparam int DEPTH       = 16;
  localparam int RECORD_BITS = 64;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int DATA_W      = 64;

  typedef logic [RECORD_BITS-1:0] rec_t;
  typedef logic [AW-1:0]          idx_t;
  typedef logic [CW-1:0]          cnt_t;

  // Commands carried in the input tuser field.
  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Result status codes carried in the output tuser field.
  typedef enum logic [2:0] {
    STS_STORED    = 3'd0,
    STS_DRAINED   = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_NOT_READY = 3'd3,
    STS_LAST      = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // One access to the ring memory.
  typedef struct packed {
    logic we;
    logic re;
    idx_t addr;
    rec_t wdata;
  } ram_req_t;

  // One result handed to the output register.
  typedef struct packed {
    logic    load;
    rec_t    record;
    status_t status;
    logic    last;
  } emit_t;

  // Advance a ring index with wrap at DEPTH.
  function automatic idx_t ring_inc(input idx_t i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

// ===== hdl/orl_ram.sv =====
module orl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port: write, or registered read that holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/orl_ctrl.sv =====
module orl_ctrl
  import orl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cmd_t     cmd,
  input  rec_t     rec,
  input  logic     storage_ready,
  input  logic     out_free,
  input  rec_t     ram_rdata,
  output ram_req_t ram_req,
  output emit_t    emit
);

  state_t state_r, state_nxt;
  idx_t   wp_r, wp_nxt;
  cnt_t   count_r, count_nxt;
  rec_t   latest_r, latest_nxt;
  idx_t   rd_idx_r, rd_idx_nxt;
  cnt_t   remain_r, remain_nxt;

  logic   in_acc;
  cnt_t   wp_ext;
  cnt_t   back;
  idx_t   oldest;

  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  // The oldest held entry sits count places behind the write position.
  assign wp_ext = CW'(wp_r);
  assign back   = (wp_ext >= count_r) ? (wp_ext - count_r)
                                      : (CW'(DEPTH) - (count_r - wp_ext));
  assign oldest = back[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wp_r     <= '0;
      count_r  <= '0;
      latest_r <= '0;
      rd_idx_r <= '0;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      count_r  <= count_nxt;
      latest_r <= latest_nxt;
      rd_idx_r <= rd_idx_nxt;
      remain_r <= remain_nxt;
    end
  end

  // Command decode and drain sequencing. The drain keeps one read in the
  // memory's data register; the next read is issued only when that record
  // moves to the output, so a stalled output simply holds the memory data.
  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    count_nxt  = count_r;
    latest_nxt = latest_r;
    rd_idx_nxt = rd_idx_r;
    remain_nxt = remain_r;
    ram_req    = '{we: 1'b0, re: 1'b0, addr: wp_r, wdata: rec};
    emit       = '{load: 1'b0, record: '0, status: STS_STORED, last: 1'b1};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_STORE: begin
              ram_req.we = 1'b1;
              wp_nxt     = ring_inc(wp_r);
              count_nxt  = (count_r == CW'(DEPTH)) ? count_r : count_r + 1'b1;
              latest_nxt = rec;
              emit.load  = 1'b1;
            end
            CMD_FLUSH: begin
              emit.load = !storage_ready || (count_r == '0);
              if (!storage_ready) begin
                emit.status = STS_NOT_READY;
              end else if (count_r == '0) begin
                emit.status = STS_EMPTY;
              end else begin
                ram_req.re   = 1'b1;
                ram_req.addr = oldest;
                rd_idx_nxt   = ring_inc(oldest);
                remain_nxt   = count_r;
                state_nxt    = ST_DRAIN;
              end
            end
            CMD_READ: begin
              emit.load   = 1'b1;
              emit.record = latest_r;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit.load   = 1'b1;
          emit.record = ram_rdata;
          if (remain_r == CW'(1)) begin
            emit.status = STS_LAST;
            state_nxt   = ST_IDLE;
            wp_nxt      = '0;
            count_nxt   = '0;
            remain_nxt  = '0;
          end else begin
            emit.status  = STS_DRAINED;
            emit.last    = 1'b0;
            ram_req.re   = 1'b1;
            ram_req.addr = rd_idx_r;
            rd_idx_nxt   = ring_inc(rd_idx_r);
            remain_nxt   = remain_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The held count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("held count above ring depth");

  // A drain always has at least one record left to deliver.
  a_drain_remain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> remain_r != '0)
    else $error("drain with nothing remaining");

  // No store may hit the memory while a drain owns it.
  a_no_write_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> !ram_req.we)
    else $error("memory write during drain");

  // After the final drained record the log is empty and idle.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load && emit.status == STS_LAST |=>
      count_r == '0 && wp_r == '0 && state_r == ST_IDLE)
    else $error("log not cleared after drain");

endmodule

// ===== hdl/overwrite_ring_log_with_drain.sv =====
// Channel | Signals                        | Contents
// in      | in_tvalid/in_tready            | tuser: command; tdata: record_in, storage_ready
// out     | out_tvalid/out_tready          | tuser: status; tdata: record_out; tlast: last
//
// Store, read, unused command and refused or empty flush are handled without leaving idle.
// A flush of N held records first reads the oldest entry, then gives one record per cycle
// while the output is free, out of the single-port ring memory.
// Reset (rst_n low, synchronous) empties the log and clears the latest record.
// A stalled output holds its result; the next input item is taken in the
// cycle the waiting result leaves.
module overwrite_ring_log_with_drain
  import orl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] record_in, [64] storage_ready, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] record_out
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);

  ram_req_t ram_req;
  emit_t    emit;
  rec_t     ram_rdata;
  logic     out_free;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_status_r;
  logic              out_last_r;

  assign out_free = !out_valid_r || out_tready;

  orl_ram #(
    .WIDTH (RECORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  orl_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .cmd           (cmd_t'(in_tuser)),
    .rec           (in_tdata[RECORD_BITS-1:0]),
    .storage_ready (in_tdata[DATA_W]),
    .out_free      (out_free),
    .ram_rdata     (ram_rdata),
    .ram_req       (ram_req),
    .emit          (emit)
  );

  // Output register: holds one result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_data_r   <= DATA_W'(emit.record);
      out_status_r <= emit.status;
      out_last_r   <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
